// ----- rtl/plel_pkg.sv -----
// Shared types and codes for the positional list engine.
// No dependencies; used by plel_ctrl and positional_list_engine.
`default_nettype none

package plel_pkg;

  localparam int OpW     = 2;
  localparam int PosW    = 6;
  localparam int ValueW  = 32;
  localparam int StatusW = 2;
  localparam int LengthW = 7;

  // operation codes
  localparam logic [OpW-1:0] OP_APPEND = 2'd0;
  localparam logic [OpW-1:0] OP_INSERT = 2'd1;
  localparam logic [OpW-1:0] OP_REMOVE = 2'd2;
  localparam logic [OpW-1:0] OP_GET    = 2'd3;

  // status codes
  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatusW-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [OpW-1:0]    opcode;
    logic [PosW-1:0]   position;
    logic [ValueW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ValueW-1:0]  read_value;
    logic [LengthW-1:0] length;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/positional_list_engine.sv -----
// Top level of the positional list engine: stream ports and the result register.
// Depends on plel_pkg and plel_ctrl (which holds plel_ram).
`default_nettype none

// Ordered list of CAPACITY entries, each ELEMENT_WIDTH bits, held in one
// simple dual-port memory with registered read data. Each request
// carries an operation in s_axis_tuser (append, insert at a position,
// remove at a position, get at a position) and gives exactly one result:
// a status in m_axis_tuser (ok, full, position out of range) and in
// m_axis_tdata the value read by a get (zero otherwise) and the length
// after the operation. Values are kept in their low ELEMENT_WIDTH bits.
// A failed request leaves the list untouched; a full list never grows.
// One request is in work at a time. Append, an error, an insert at the
// length and a removal of the last entry are settled in S_CHECK; a get
// reads the memory there and takes the value in S_GETW. Insert at a
// position p below the length shifts entries up in S_SHUP, then writes
// the value in S_PUT; remove at p shifts entries down in S_SHDN. The
// shift moves one entry per cycle through the memory, reading one
// address while writing the one behind it, so the longest request is an
// insert at the head of a list of CAPACITY - 1 entries. The next request
// is taken once the sequencer is back in idle after its result has left.
// A finished result waits in the output register, and the next request
// is taken meanwhile; a second result waits in the sequencer until the
// first is drained. The memory needs no clearing after reset: only entries below the length are read.

module positional_list_engine import plel_pkg::*; #(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,  // [5:0] position, [37:6] value, [39:38] zero
  input  wire logic [1:0]  s_axis_tuser_i,  // [1:0] opcode
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [39:0] m_axis_tdata_o,  // [31:0] read_value, [38:32] length, [39] zero
  output logic      [1:0]  m_axis_tuser_o   // [1:0] status
);

  req_t req;
  res_t res, out_q;
  logic res_valid, res_ready;
  logic out_valid_q, out_valid_d;

  assign req.opcode   = s_axis_tuser_i;
  assign req.position = s_axis_tdata_i[PosW-1:0];
  assign req.value    = s_axis_tdata_i[PosW+ValueW-1:PosW];

  plel_ctrl #(
    .Capacity (CAPACITY),
    .ElemW    (ELEMENT_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // result register: takes a new result when empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.length, out_q.read_value};
  assign m_axis_tuser_o  = out_q.status;

endmodule

`default_nettype wire

// ----- rtl/plel_ram.sv -----
// Simple dual-port entry store: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module plel_ram #(
  parameter int Depth = 64,
  parameter int Width = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/plel_ctrl.sv -----
// Request sequencer: range checks, entry shifting through the store, length count.
// Depends on plel_pkg and plel_ram.
`default_nettype none

module plel_ctrl import plel_pkg::*; #(
  parameter int Capacity = 64,
  parameter int ElemW    = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  input  wire req_t req_i,
  output logic      res_valid_o,
  input  wire logic res_ready_i,
  output res_t      res_o
);

  localparam int AW   = $clog2(Capacity);
  localparam int CW   = $clog2(Capacity + 1);
  localparam int CmpW = (CW > PosW) ? CW : PosW;
  localparam int ValW = (ElemW < ValueW) ? ElemW : ValueW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SHUP  = 3'd2;
  localparam logic [2:0] S_SHDN  = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;
  localparam logic [2:0] S_GETW  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [OpW-1:0]      op_q;
  logic [PosW-1:0]     pos_q;
  logic [ElemW-1:0]    val_q;
  logic [AW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [StatusW-1:0]  status_q, status_d;
  logic [ValueW-1:0]   rdv_q, rdv_d;

  logic                we, re;
  logic [AW-1:0]       waddr, raddr;
  logic [ElemW-1:0]    wdata, rdata;

  logic [CmpW-1:0]     pos_c, cnt_c;
  logic [AW-1:0]       pos_a, last_a;
  logic                full, accept;

  plel_ram #(
    .Depth (Capacity),
    .Width (ElemW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign pos_c  = CmpW'(pos_q);
  assign cnt_c  = CmpW'(count_q);
  assign pos_a  = AW'(pos_q);
  assign last_a = AW'(count_q - 1'b1);
  assign full   = (count_q == CW'(Capacity));
  assign accept = req_valid_i && req_ready_o;

  assign req_ready_o       = (state_q == S_IDLE);
  assign res_valid_o       = (state_q == S_DONE);
  assign res_o.status      = status_q;
  assign res_o.read_value  = rdv_q;
  assign res_o.length      = LengthW'(count_q);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    rd_ptr_d = rd_ptr_q;
    status_d = status_q;
    rdv_d    = rdv_q;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    re       = 1'b0;
    raddr    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          state_d  = S_CHECK;
          status_d = ST_OK;
          rdv_d    = '0;
        end
      end
      S_CHECK: begin
        unique case (op_q)
          OP_APPEND: begin
            state_d = S_DONE;
            if (full) begin
              status_d = ST_FULL;
            end else begin
              we      = 1'b1;
              waddr   = AW'(count_q);
              wdata   = val_q;
              count_d = count_q + 1'b1;
            end
          end
          OP_INSERT: begin
            if (full) begin
              status_d = ST_FULL;
              state_d  = S_DONE;
            end else if (pos_c > cnt_c) begin
              status_d = ST_RANGE;
              state_d  = S_DONE;
            end else if (pos_c == cnt_c) begin
              // insert at the end is an append
              we      = 1'b1;
              waddr   = pos_a;
              wdata   = val_q;
              count_d = count_q + 1'b1;
              state_d = S_DONE;
            end else begin
              re       = 1'b1;
              raddr    = last_a;
              rd_ptr_d = last_a;
              state_d  = S_SHUP;
            end
          end
          OP_REMOVE: begin
            if (pos_c >= cnt_c) begin
              status_d = ST_RANGE;
              state_d  = S_DONE;
            end else if (pos_c + 1'b1 == cnt_c) begin
              // last entry: nothing to move
              count_d = count_q - 1'b1;
              state_d = S_DONE;
            end else begin
              re       = 1'b1;
              raddr    = AW'(pos_a + 1'b1);
              rd_ptr_d = AW'(pos_a + 1'b1);
              state_d  = S_SHDN;
            end
          end
          OP_GET: begin
            if (pos_c >= cnt_c) begin
              status_d = ST_RANGE;
              state_d  = S_DONE;
            end else begin
              re      = 1'b1;
              raddr   = pos_a;
              state_d = S_GETW;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_SHUP: begin
        // write behind the descending read pointer
        we    = 1'b1;
        waddr = AW'(rd_ptr_q + 1'b1);
        wdata = rdata;
        if (rd_ptr_q == pos_a) begin
          state_d = S_PUT;
        end else begin
          re       = 1'b1;
          raddr    = AW'(rd_ptr_q - 1'b1);
          rd_ptr_d = AW'(rd_ptr_q - 1'b1);
        end
      end
      S_PUT: begin
        we      = 1'b1;
        waddr   = pos_a;
        wdata   = val_q;
        count_d = count_q + 1'b1;
        state_d = S_DONE;
      end
      S_SHDN: begin
        // write behind the ascending read pointer
        we    = 1'b1;
        waddr = AW'(rd_ptr_q - 1'b1);
        wdata = rdata;
        if (rd_ptr_q == last_a) begin
          count_d = count_q - 1'b1;
          state_d = S_DONE;
        end else begin
          re       = 1'b1;
          raddr    = AW'(rd_ptr_q + 1'b1);
          rd_ptr_d = AW'(rd_ptr_q + 1'b1);
        end
      end
      S_GETW: begin
        rdv_d   = ValueW'(rdata[ValW-1:0]);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q <= rd_ptr_d;
    status_q <= status_d;
    rdv_q    <= rdv_d;
    if (accept) begin
      op_q  <= req_i.opcode;
      pos_q <= req_i.position;
      val_q <= ElemW'(req_i.value[ValW-1:0]);
    end
  end

endmodule

`default_nettype wire
